/* hdl/pmlt3_pkg.sv */
// Package for the T3 multilook averager: widths, state codes, lane control type.
// No dependencies; used by pmlt3_lane and the top level (pmlt3_ram does not use it).
`default_nettype none
package pmlt3_pkg;

  localparam int MAX_OUT_COLS = 1024;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ACC_WIDTH    = 48;
  localparam int NCH          = 9;
  localparam int OUT_WIDTH    = 32;
  localparam int COMB_WIDTH   = ACC_WIDTH + 3;
  localparam int DEN_WIDTH    = 12;
  localparam int COL_AW       = $clog2(MAX_OUT_COLS);
  localparam int ROW_WIDTH    = NCH * ACC_WIDTH;
  localparam int IN_TDATA_W   = NCH * SAMPLE_WIDTH;
  localparam int OUT_TDATA_W  = ((NCH * OUT_WIDTH + COL_AW + 7) / 8) * 8;
  localparam int INV_SHIFT    = 30;
  localparam logic [INV_SHIFT-1:0] INV_SQRT2_Q30 = 30'd759250125;

  localparam logic [2:0] CFG_LINE_WIDTH = 3'd0;
  localparam logic [2:0] CFG_ROW_OFFSET = 3'd1;
  localparam logic [2:0] CFG_COL_OFFSET = 3'd2;
  localparam logic [2:0] CFG_LOOK_COLS  = 3'd3;
  localparam logic [2:0] CFG_LOOK_ROWS  = 3'd4;
  localparam logic [2:0] CFG_OUT_COLS   = 3'd5;
  localparam logic [2:0] CFG_OUT_FORMAT = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_RD, ST_ACC, ST_LANES, ST_PUSH
  } state_t;

  typedef struct packed {
    logic                 start;
    logic                 use_h;
    logic [DEN_WIDTH-1:0] den;
  } lane_ctl_t;

endpackage
`default_nettype wire

/* hdl/pmlt3_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module pmlt3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/pmlt3_lane.sv */
// One output lane: signed divide by ctl.den, the look count or twice it (one bit per cycle),
// optional 1/sqrt2 scaling, saturation to 32 bits. Uses pmlt3_pkg.
`default_nettype none
module pmlt3_lane (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire pmlt3_pkg::lane_ctl_t                   ctl,
  input  wire logic signed [pmlt3_pkg::COMB_WIDTH-1:0] num,
  output logic             [pmlt3_pkg::OUT_WIDTH-1:0]  res,
  output logic                                        done
);
  import pmlt3_pkg::*;

  localparam int CW  = COMB_WIDTH;
  localparam int CNW = $clog2(CW + 1);
  localparam int QW  = 33;
  localparam int PW  = QW + INV_SHIFT;

  logic                 div_r, mul_r, fin_r, done_r;
  logic [CNW-1:0]       cnt_r;
  logic                 neg_r, use_h_r;
  logic [DEN_WIDTH-1:0] den_r, rem_r;
  logic [CW-1:0]        quo_r;
  logic [PW-1:0]        prod_r;
  logic [OUT_WIDTH-1:0] res_r;

  logic [DEN_WIDTH:0]   rem_sh, rem_sub;
  logic                 ge;
  logic [QW-1:0]        qclamp;
  logic [CW-1:0]        mag;
  logic [OUT_WIDTH-1:0] res_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[CW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    // clamp the quotient magnitude to 2^32 before scaling
    qclamp  = (quo_r > CW'(64'h1_0000_0000)) ? 33'h1_0000_0000 : quo_r[QW-1:0];
    mag     = use_h_r ? CW'(prod_r[PW-1:INV_SHIFT]) : quo_r;
    if (!neg_r) begin
      res_nxt = (mag > CW'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag[OUT_WIDTH-1:0];
    end else begin
      res_nxt = (mag > CW'(32'h8000_0000)) ? 32'h8000_0000 : (~mag[OUT_WIDTH-1:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r  <= 1'b0;
      mul_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        div_r <= 1'b1;
        cnt_r <= CNW'(CW);
      end else if (div_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          div_r <= 1'b0;
          mul_r <= 1'b1;
        end
      end
      if (mul_r) begin
        mul_r <= 1'b0;
        fin_r <= 1'b1;
      end
      if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg_r   <= num[CW-1];
      quo_r   <= num[CW-1] ? (~num + CW'(1)) : num;
      rem_r   <= '0;
      den_r   <= ctl.den;
      use_h_r <= ctl.use_h;
    end else if (div_r) begin
      rem_r <= ge ? rem_sub[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
      quo_r <= {quo_r[CW-2:0], ge};
    end
    if (mul_r) begin
      prod_r <= PW'(qclamp) * PW'(INV_SQRT2_Q30);
    end
    if (fin_r) begin
      res_r <= res_nxt;
    end
  end

  assign res  = res_r;
  assign done = done_r;
endmodule
`default_nettype wire

/* hdl/polsar_multilook_t3_c3.sv */
// Top level of the T3 multilook averager with optional C3 output.
// Uses pmlt3_pkg, pmlt3_ram (column sums) and nine pmlt3_lane instances.
`default_nettype none
// Pixels of a 3x3 coherency matrix enter in raster order on in_*; each
// look_rows x look_cols block is summed per output column in a 1024-row RAM
// and its average (T3) or the derived C3 matrix leaves on out_*, tlast
// marking the last column of an output row. After reset the RAM is cleared
// row by row before the first pixel is taken. A pixel outside the window
// leaves the input ready; a pixel inside holds in_tready low through a
// 14-step column divide, RAM read and update, and a pixel that closes a block
// also through 51 divide steps in the nine parallel lanes, scaling,
// saturation, handoff to the output register and any output stall.
module polsar_multilook_t3_c3 (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // t11, t12_re, t12_im, t13_re, t13_im, t22, t23_re, t23_im, t33 (32 b each)
  input  wire logic [pmlt3_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // m11, m12_re, m12_im, m13_re, m13_im, m22, m23_re, m23_im, m33 (32 b each),
  // out_column (10 b), zero pad
  output logic [pmlt3_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                       out_tlast,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [2:0]                            cfg_index,
  input  wire logic [15:0]                           cfg_data
);
  import pmlt3_pkg::*;

  state_t state_r, state_nxt;

  logic [14:0] line_width_r;
  logic [15:0] row_offset_r;
  logic [13:0] col_offset_r;
  logic [5:0]  look_cols_r, look_rows_r;
  logic [10:0] out_cols_r;
  logic        out_format_r;

  logic [13:0] col_r;
  logic [4:0]  lrc_r;
  logic [15:0] skip_r;
  logic [COL_AW:0] clr_r;

  logic [IN_TDATA_W-1:0] data_r;
  logic        first_r, last_look_r;
  logic [13:0] dq_r;
  logic [5:0]  drem_r;
  logic [3:0]  dcnt_r;
  logic [COL_AW-1:0] oc_out_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_last_r;

  // clamped configuration
  logic [14:0] lw_c;
  logic [5:0]  lc_c, lr_c;
  logic [10:0] ocn_c;
  logic        accept, skipping, last_look, in_win;
  logic [13:0] rel;
  logic [16:0] win_len;

  logic [6:0]  rsh;
  logic        dge;
  logic [6:0]  rsub;

  logic              ram_we;
  logic [COL_AW-1:0] ram_addr;
  logic [ROW_WIDTH-1:0] ram_wdata, ram_rdata;

  logic [ACC_WIDTH-1:0]        acc_new [NCH];
  logic signed [COMB_WIDTH-1:0] sx [NCH];
  logic signed [COMB_WIDTH-1:0] comb [NCH];
  logic [ROW_WIDTH-1:0]        row_new;
  logic        load, emit;
  logic [DEN_WIDTH-1:0] n1, n2;
  lane_ctl_t   lane_ctl [NCH];
  logic [OUT_WIDTH-1:0] lane_res [NCH];
  logic [NCH-1:0]      lane_done;

  always_comb begin
    lw_c  = (line_width_r == '0) ? 15'd1 : (line_width_r > 15'd16384) ? 15'd16384 : line_width_r;
    lc_c  = (look_cols_r == '0) ? 6'd1 : (look_cols_r > 6'd32) ? 6'd32 : look_cols_r;
    lr_c  = (look_rows_r == '0) ? 6'd1 : (look_rows_r > 6'd32) ? 6'd32 : look_rows_r;
    ocn_c = (out_cols_r == '0) ? 11'd1
          : (out_cols_r > 11'(MAX_OUT_COLS)) ? 11'(MAX_OUT_COLS) : out_cols_r;
    accept    = in_tvalid && in_tready;
    skipping  = skip_r < row_offset_r;
    last_look = {1'b0, lrc_r} >= (lr_c - 6'd1);
    rel       = col_r - col_offset_r;
    win_len   = 17'(ocn_c) * 17'(lc_c);
    in_win    = !skipping && (col_r >= col_offset_r) && (17'(rel) < win_len);
    rsh       = {drem_r, dq_r[13]};
    dge       = rsh >= {1'b0, lc_c};
    rsub      = rsh - {1'b0, lc_c};
  end

  // accumulate and form the combinations that feed the lanes
  always_comb begin
    load = first_r && (drem_r == '0);
    emit = last_look_r && (drem_r == lc_c - 6'd1);
    for (int i = 0; i < NCH; i++) begin
      acc_new[i] = (load ? '0 : ram_rdata[i*ACC_WIDTH +: ACC_WIDTH])
                 + {{(ACC_WIDTH-SAMPLE_WIDTH){data_r[i*SAMPLE_WIDTH+SAMPLE_WIDTH-1]}},
                    data_r[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]};
      sx[i] = {{(COMB_WIDTH-ACC_WIDTH){acc_new[i][ACC_WIDTH-1]}}, acc_new[i]};
      row_new[i*ACC_WIDTH +: ACC_WIDTH] = emit ? '0 : acc_new[i];
    end
    n1 = DEN_WIDTH'(lr_c) * DEN_WIDTH'(lc_c);
    n2 = {n1[DEN_WIDTH-2:0], 1'b0};
    if (!out_format_r) begin
      for (int i = 0; i < NCH; i++) begin
        comb[i] = sx[i];
      end
    end else begin
      comb[0] = sx[0] + sx[5] + sx[1] + sx[1];
      comb[1] = sx[3] + sx[6];
      comb[2] = sx[4] + sx[7];
      comb[3] = sx[0] - sx[5];
      comb[4] = -sx[2];
      comb[5] = sx[8];
      comb[6] = sx[3] - sx[6];
      comb[7] = sx[7] - sx[4];
      comb[8] = sx[0] + sx[5] - sx[1] - sx[1];
    end
    for (int i = 0; i < NCH; i++) begin
      lane_ctl[i].start = (state_r == ST_ACC) && emit;
      lane_ctl[i].use_h = out_format_r && (i == 1 || i == 2 || i == 6 || i == 7);
      lane_ctl[i].den   = (out_format_r && (i == 0 || i == 3 || i == 8)) ? n2 : n1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ram_we    = 1'b0;
    ram_addr  = dq_r[COL_AW-1:0];
    ram_wdata = row_new;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r[COL_AW-1:0];
        ram_wdata = '0;
        if (clr_r == (COL_AW+1)'(MAX_OUT_COLS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE:  if (accept && in_win) state_nxt = ST_DIV;
      ST_DIV:   if (dcnt_r == 4'd1) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_ACC;
      ST_ACC: begin
        ram_we    = 1'b1;
        state_nxt = emit ? ST_LANES : ST_IDLE;
      end
      ST_LANES: if (&lane_done) state_nxt = ST_PUSH;
      ST_PUSH:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      line_width_r <= 15'd1;
      row_offset_r <= '0;
      col_offset_r <= '0;
      look_cols_r  <= 6'd1;
      look_rows_r  <= 6'd1;
      out_cols_r   <= 11'd1;
      out_format_r <= 1'b0;
      col_r        <= '0;
      lrc_r        <= '0;
      skip_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + (COL_AW+1)'(1);
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LINE_WIDTH: line_width_r <= cfg_data[14:0];
          CFG_ROW_OFFSET: row_offset_r <= cfg_data;
          CFG_COL_OFFSET: col_offset_r <= cfg_data[13:0];
          CFG_LOOK_COLS:  look_cols_r  <= cfg_data[5:0];
          CFG_LOOK_ROWS:  look_rows_r  <= cfg_data[5:0];
          CFG_OUT_COLS:   out_cols_r   <= cfg_data[10:0];
          CFG_OUT_FORMAT: out_format_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        if ({1'b0, col_r} >= lw_c - 15'd1) begin
          col_r <= '0;
          if (skipping) skip_r <= skip_r + 16'd1;
          else lrc_r <= last_look ? 5'd0 : lrc_r + 5'd1;
        end else begin
          col_r <= col_r + 14'd1;
        end
      end
      if (state_r == ST_PUSH && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r      <= in_tdata;
      first_r     <= lrc_r == '0;
      last_look_r <= last_look;
      dq_r        <= rel;
      drem_r      <= '0;
      dcnt_r      <= 4'd14;
    end else if (state_r == ST_DIV) begin
      drem_r <= dge ? rsub[5:0] : rsh[5:0];
      dq_r   <= {dq_r[12:0], dge};
      dcnt_r <= dcnt_r - 4'd1;
    end
    if (state_r == ST_ACC) oc_out_r <= dq_r[COL_AW-1:0];
    if (state_r == ST_PUSH && (!out_valid_r || out_tready)) begin
      for (int i = 0; i < NCH; i++) begin
        out_data_r[i*OUT_WIDTH +: OUT_WIDTH] <= lane_res[i];
      end
      out_data_r[OUT_TDATA_W-1:NCH*OUT_WIDTH] <= (OUT_TDATA_W-NCH*OUT_WIDTH)'(oc_out_r);
      out_last_r <= {1'b0, oc_out_r} == (ocn_c - 11'd1);
    end
  end

  pmlt3_ram #(.WIDTH(ROW_WIDTH), .DEPTH(MAX_OUT_COLS)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  for (genvar g = 0; g < NCH; g++) begin : g_lane
    pmlt3_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl[g]),
      .num   (comb[g]),
      .res   (lane_res[g]),
      .done  (lane_done[g])
    );
  end

  assign in_tready  = state_r == ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
endmodule
`default_nettype wire
